[hdl/rcvg_pkg.sv]
// Shared types and fixed constants of the cos^4 radial vignette gain block.
`timescale 1ns / 1ps
package rcvg_pkg;

  localparam int unsigned DIM_W      = 13;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned LIGHT_W    = 8;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned STR_W      = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned D2_W       = 25;
  localparam int unsigned DQ_W       = 21;
  localparam int unsigned CORNER_W   = 21;
  localparam int unsigned DEN_W      = 37;
  localparam int unsigned FRAC_SHIFT = 24;
  localparam int unsigned DIV_STEPS  = 45;
  localparam int unsigned PSQ_STEPS  = 21;
  localparam int unsigned PSQ_V_W    = 42;
  localparam int unsigned PSQ_REM_W  = 24;
  localparam int unsigned CSQ_STEPS  = 22;
  localparam int unsigned CSQ_V_W    = 44;
  localparam int unsigned CSQ_REM_W  = 25;
  localparam int unsigned MOD_W      = 18;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  localparam logic [MOD_W-1:0]      PI_Q16         = 18'd205887;
  localparam logic [CORNER_W-1:0]   CORNER_MAX     = 21'h1FFFFF;
  localparam logic [DIM_W-1:0]      WIDTH_RESET    = 13'd640;
  localparam logic [DIM_W-1:0]      HEIGHT_RESET   = 13'd480;
  localparam logic [STR_W-1:0]      STRENGTH_RESET = 16'd256;
  localparam logic [CORNER_W-1:0]   CORNER_RESET   = 21'd102400;
  localparam logic [DEN_W-1:0]      DENOM_RESET    = 37'd26214400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_STRENGTH     = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CFG_IDLE,
    CFG_LOAD,
    CFG_ITER,
    CFG_DENOM
  } cfg_state_e;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
    logic [LIGHT_W-1:0] lightness_in;
  } item_in_t;

  typedef struct packed {
    logic [LIGHT_W-1:0] lightness_out;
    logic [GAIN_W-1:0]  radial_gain;
  } item_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [DEN_W-1:0]   denom;
    logic               denom_zero;
  } cfg_view_t;

  typedef struct packed {
    logic [D2_W-1:0]    d2;
    logic [LIGHT_W-1:0] lin;
  } fifo_entry_t;

endpackage

[hdl/rcvg_cfg.sv]
// Configuration registers, corner distance square root sequencer and divisor register.
`timescale 1ns / 1ps
module rcvg_cfg #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rcvg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rcvg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output rcvg_pkg::cfg_view_t                 view_o,
  output logic                                busy_o
);

  rcvg_pkg::cfg_state_e state_q, state_d;

  logic [rcvg_pkg::DIM_W-1:0]     width_q, height_q;
  logic [rcvg_pkg::STR_W-1:0]     strength_q;
  logic [rcvg_pkg::CORNER_W-1:0]  corner_q;
  logic [rcvg_pkg::DEN_W-1:0]     denom_q;
  logic [rcvg_pkg::CSQ_V_W-1:0]   v_q;
  logic [rcvg_pkg::CSQ_REM_W-1:0] rem_q;
  logic [rcvg_pkg::CSQ_STEPS-1:0] root_q;
  logic [4:0]                     cnt_q;

  logic wr_size, wr_str, load_en, iter_en;
  logic [rcvg_pkg::DIM_W-1:0]     wsat, hsat, dx, dy;
  logic [rcvg_pkg::COORD_W-1:0]   cx, cy;
  logic [26:0]                    best;
  logic [rcvg_pkg::CSQ_REM_W-1:0] rem_n, trial, rem_next;
  logic [rcvg_pkg::CSQ_STEPS-1:0] root_next;
  logic                           last_step;

  assign wr_size = cfg_we_i && (cfg_idx_i == rcvg_pkg::REG_IMAGE_WIDTH ||
                                cfg_idx_i == rcvg_pkg::REG_IMAGE_HEIGHT);
  assign wr_str  = cfg_we_i && (cfg_idx_i == rcvg_pkg::REG_STRENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= rcvg_pkg::WIDTH_RESET;
      height_q   <= rcvg_pkg::HEIGHT_RESET;
      strength_q <= rcvg_pkg::STRENGTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcvg_pkg::REG_IMAGE_WIDTH:  width_q    <= cfg_data_i[rcvg_pkg::DIM_W-1:0];
        rcvg_pkg::REG_IMAGE_HEIGHT: height_q   <= cfg_data_i[rcvg_pkg::DIM_W-1:0];
        rcvg_pkg::REG_STRENGTH:     strength_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    wsat = (32'(width_q) > MAX_DIM) ? rcvg_pkg::DIM_W'(MAX_DIM) : width_q;
    hsat = (32'(height_q) > MAX_DIM) ? rcvg_pkg::DIM_W'(MAX_DIM) : height_q;
    cx   = wsat[rcvg_pkg::DIM_W-1:1];
    cy   = hsat[rcvg_pkg::DIM_W-1:1];
    dx   = wsat - {1'b0, cx};
    dy   = hsat - {1'b0, cy};
    best = 27'(dx * dx) + 27'(dy * dy);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcvg_pkg::CFG_IDLE:  if (wr_str) state_d = rcvg_pkg::CFG_DENOM;
      rcvg_pkg::CFG_LOAD:  state_d = rcvg_pkg::CFG_ITER;
      rcvg_pkg::CFG_ITER:  if (last_step) state_d = rcvg_pkg::CFG_DENOM;
      rcvg_pkg::CFG_DENOM: state_d = rcvg_pkg::CFG_IDLE;
      default:             state_d = rcvg_pkg::CFG_IDLE;
    endcase
    if (wr_size) state_d = rcvg_pkg::CFG_LOAD;
  end

  always_comb begin
    busy_o  = (state_q != rcvg_pkg::CFG_IDLE);
    load_en = (state_q == rcvg_pkg::CFG_LOAD);
    iter_en = (state_q == rcvg_pkg::CFG_ITER);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcvg_pkg::CFG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    last_step = (cnt_q == 5'(rcvg_pkg::CSQ_STEPS - 1));
    rem_n     = {rem_q[rcvg_pkg::CSQ_REM_W-3:0], v_q[rcvg_pkg::CSQ_V_W-1 -: 2]};
    trial     = {1'b0, root_q, 2'b01};
    if (rem_n >= trial) begin
      rem_next  = rem_n - trial;
      root_next = {root_q[rcvg_pkg::CSQ_STEPS-2:0], 1'b1};
    end else begin
      rem_next  = rem_n;
      root_next = {root_q[rcvg_pkg::CSQ_STEPS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      rem_q    <= '0;
      root_q   <= '0;
      cnt_q    <= '0;
      corner_q <= rcvg_pkg::CORNER_RESET;
      denom_q  <= rcvg_pkg::DENOM_RESET;
    end else begin
      denom_q <= rcvg_pkg::DEN_W'(corner_q * strength_q);
      if (load_en) begin
        v_q    <= {1'b0, best, 16'b0};
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
      end else if (iter_en) begin
        v_q    <= {v_q[rcvg_pkg::CSQ_V_W-3:0], 2'b00};
        rem_q  <= rem_next;
        root_q <= root_next;
        cnt_q  <= cnt_q + 5'd1;
        if (last_step) begin
          corner_q <= root_next[rcvg_pkg::CSQ_STEPS-1] ? rcvg_pkg::CORNER_MAX :
                      root_next[rcvg_pkg::CORNER_W-1:0];
        end
      end
    end
  end

  assign view_o.cx         = cx;
  assign view_o.cy         = cy;
  assign view_o.denom      = denom_q;
  assign view_o.denom_zero = (denom_q == '0);

endmodule

[hdl/rcvg_front.sv]
// Front end: takes items, forms the center offsets and the squared radius.
`timescale 1ns / 1ps
module rcvg_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  rcvg_pkg::item_in_t    item_i,
  input  rcvg_pkg::cfg_view_t   view_i,
  input  logic                  full_i,
  output logic                  push_o,
  output rcvg_pkg::fifo_entry_t entry_o,
  output logic                  stall_o
);

  logic                         s1_v_q, s2_v_q, adv;
  logic [rcvg_pkg::COORD_W-1:0] dr_q, dc_q, dr, dc;
  logic [rcvg_pkg::LIGHT_W-1:0] l1_q, l2_q;
  logic [2*rcvg_pkg::COORD_W-1:0] sqr_q, sqc_q;

  assign adv     = !(s2_v_q && full_i);
  assign stall_o = !adv;
  assign push_o  = s2_v_q && !full_i;

  always_comb begin
    dr = (item_i.pixel_row > view_i.cy) ? item_i.pixel_row - view_i.cy
                                        : view_i.cy - item_i.pixel_row;
    dc = (item_i.pixel_col > view_i.cx) ? item_i.pixel_col - view_i.cx
                                        : view_i.cx - item_i.pixel_col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= take_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dr_q  <= dr;
      dc_q  <= dc;
      l1_q  <= item_i.lightness_in;
      sqr_q <= dr_q * dr_q;
      sqc_q <= dc_q * dc_q;
      l2_q  <= l1_q;
    end
  end

  assign entry_o.d2  = rcvg_pkg::D2_W'(sqr_q) + rcvg_pkg::D2_W'(sqc_q);
  assign entry_o.lin = l2_q;

endmodule

[hdl/rcvg_fifo.sv]
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module rcvg_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rcvg_pkg::fifo_entry_t wdata_i,
  input  logic                  pop_i,
  output rcvg_pkg::fifo_entry_t rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  rcvg_pkg::fifo_entry_t            mem_q [rcvg_pkg::FIFO_DEPTH];
  logic [rcvg_pkg::FIFO_AW-1:0]     wr_q, rd_q;
  logic [rcvg_pkg::FIFO_AW:0]       cnt_q;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == (rcvg_pkg::FIFO_AW+1)'(rcvg_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

endmodule

[hdl/rcvg_back.sv]
// Back end: radius square root, angle division with reduction by pi, gain lookup, scaling.
`timescale 1ns / 1ps
module rcvg_back #(
  parameter int unsigned GAIN_TABLE_DEPTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  rcvg_pkg::fifo_entry_t entry_i,
  input  rcvg_pkg::cfg_view_t   view_i,
  output logic                  strobe_o,
  output rcvg_pkg::item_out_t   result_o
);

  localparam int unsigned IdxW = $clog2(GAIN_TABLE_DEPTH);

  typedef struct packed {
    logic                             v;
    logic [rcvg_pkg::LIGHT_W-1:0]     lin;
    logic [rcvg_pkg::PSQ_V_W-1:0]     rad;
    logic [rcvg_pkg::PSQ_REM_W-1:0]   rem;
    logic [rcvg_pkg::DQ_W-1:0]        root;
  } sq_stage_t;

  typedef struct packed {
    logic                             v;
    logic [rcvg_pkg::LIGHT_W-1:0]     lin;
    logic [rcvg_pkg::DQ_W-1:0]        dq;
    logic [rcvg_pkg::DEN_W-1:0]       r;
    logic [rcvg_pkg::MOD_W-1:0]       m;
  } div_stage_t;

  typedef struct packed {
    logic                             v;
    logic [rcvg_pkg::LIGHT_W-1:0]     lin;
    logic [rcvg_pkg::MOD_W-1:0]       rr;
    logic [IdxW-1:0]                  low;
    logic [IdxW-1:0]                  idx;
  } idx_stage_t;

  function automatic logic [rcvg_pkg::GAIN_W-1:0] cos4_entry(input int unsigned k);
    logic [63:0]        kk, x, x2, term, c, c2, c4;
    logic signed [63:0] sum;
    kk   = (2 * k > GAIN_TABLE_DEPTH) ? 64'(GAIN_TABLE_DEPTH - k) : 64'(k);
    x    = (64'd3373259426 * kk) / 64'(GAIN_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = $signed(term);
    term = ((term * x2) >> 30) / 64'd2;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd12;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd30;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd56;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd90;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd132; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd182; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd240; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd306; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd380; sum = sum + $signed(term);
    if (sum < 0) begin
      c = '0;
    end else if (sum > $signed(64'd1 << 30)) begin
      c = 64'd1 << 30;
    end else begin
      c = 64'(sum);
    end
    c2 = (c * c) >> 30;
    c4 = (c2 * c2) >> 30;
    return rcvg_pkg::GAIN_W'((c4 * 64'd65535 + 64'd536870912) >> 30);
  endfunction

  // Square root of the squared radius in Q.8, one result bit per stage.
  sq_stage_t sq_in;
  sq_stage_t sq_q [rcvg_pkg::PSQ_STEPS+1];

  assign sq_in.v    = valid_i;
  assign sq_in.lin  = entry_i.lin;
  assign sq_in.rad  = {1'b0, entry_i.d2, 16'b0};
  assign sq_in.rem  = '0;
  assign sq_in.root = '0;

  for (genvar s = 0; s < rcvg_pkg::PSQ_STEPS; s++) begin : g_sq
    sq_stage_t                      cur;
    logic [rcvg_pkg::PSQ_REM_W-1:0] rem_n, trial;
    if (s == 0) begin : g_first
      assign cur = sq_in;
    end else begin : g_next
      assign cur = sq_q[s];
    end
    assign rem_n = {cur.rem[rcvg_pkg::PSQ_REM_W-3:0], cur.rad[rcvg_pkg::PSQ_V_W-1 -: 2]};
    assign trial = {1'b0, cur.root, 2'b01};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[s+1] <= '0;
      end else begin
        sq_q[s+1].v   <= cur.v;
        sq_q[s+1].lin <= cur.lin;
        sq_q[s+1].rad <= {cur.rad[rcvg_pkg::PSQ_V_W-3:0], 2'b00};
        if (rem_n >= trial) begin
          sq_q[s+1].rem  <= rem_n - trial;
          sq_q[s+1].root <= {cur.root[rcvg_pkg::DQ_W-2:0], 1'b1};
        end else begin
          sq_q[s+1].rem  <= rem_n;
          sq_q[s+1].root <= {cur.root[rcvg_pkg::DQ_W-2:0], 1'b0};
        end
      end
    end
  end

  // Restoring division of dq * 2^24 by the divisor; the quotient is reduced by pi on the fly.
  div_stage_t div_in;
  div_stage_t div_q [rcvg_pkg::DIV_STEPS+1];

  assign div_in.v   = sq_q[rcvg_pkg::PSQ_STEPS].v;
  assign div_in.lin = sq_q[rcvg_pkg::PSQ_STEPS].lin;
  assign div_in.dq  = sq_q[rcvg_pkg::PSQ_STEPS].root;
  assign div_in.r   = '0;
  assign div_in.m   = '0;

  for (genvar k = 0; k < rcvg_pkg::DIV_STEPS; k++) begin : g_div
    localparam int NumBit = rcvg_pkg::DIV_STEPS - 1 - k;
    div_stage_t                   cur;
    logic                         nbit, qbit;
    logic [rcvg_pkg::DEN_W:0]     rn;
    logic [rcvg_pkg::MOD_W:0]     mn;
    if (k == 0) begin : g_first
      assign cur = div_in;
    end else begin : g_next
      assign cur = div_q[k];
    end
    if (NumBit >= rcvg_pkg::FRAC_SHIFT) begin : g_nb
      assign nbit = cur.dq[NumBit - rcvg_pkg::FRAC_SHIFT];
    end else begin : g_zb
      assign nbit = 1'b0;
    end
    assign rn   = {cur.r, nbit};
    assign qbit = !view_i.denom_zero && (rn >= {1'b0, view_i.denom});
    assign mn   = {cur.m, qbit};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_q[k+1] <= '0;
      end else begin
        div_q[k+1].v   <= cur.v;
        div_q[k+1].lin <= cur.lin;
        div_q[k+1].dq  <= cur.dq;
        div_q[k+1].r   <= qbit ? rcvg_pkg::DEN_W'(rn - {1'b0, view_i.denom})
                               : rn[rcvg_pkg::DEN_W-1:0];
        div_q[k+1].m   <= (mn >= {1'b0, rcvg_pkg::PI_Q16})
                          ? rcvg_pkg::MOD_W'(mn - {1'b0, rcvg_pkg::PI_Q16})
                          : mn[rcvg_pkg::MOD_W-1:0];
      end
    end
  end

  // Table index = floor(remainder * depth / pi), one index bit per stage.
  idx_stage_t ix_in;
  idx_stage_t ix_q [IdxW+1];
  logic [rcvg_pkg::MOD_W+IdxW-1:0] ix_num;

  assign ix_num    = (rcvg_pkg::MOD_W+IdxW)'(div_q[rcvg_pkg::DIV_STEPS].m) *
                     (rcvg_pkg::MOD_W+IdxW)'(GAIN_TABLE_DEPTH);
  assign ix_in.v   = div_q[rcvg_pkg::DIV_STEPS].v;
  assign ix_in.lin = div_q[rcvg_pkg::DIV_STEPS].lin;
  assign ix_in.rr  = ix_num[rcvg_pkg::MOD_W+IdxW-1 -: rcvg_pkg::MOD_W];
  assign ix_in.low = ix_num[IdxW-1:0];
  assign ix_in.idx = '0;

  for (genvar j = 0; j < IdxW; j++) begin : g_idx
    idx_stage_t               cur;
    logic [rcvg_pkg::MOD_W:0] t;
    logic                     ge;
    if (j == 0) begin : g_first
      assign cur = ix_in;
    end else begin : g_next
      assign cur = ix_q[j];
    end
    assign t  = {cur.rr, cur.low[IdxW-1]};
    assign ge = (t >= {1'b0, rcvg_pkg::PI_Q16});
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ix_q[j+1] <= '0;
      end else begin
        ix_q[j+1].v   <= cur.v;
        ix_q[j+1].lin <= cur.lin;
        ix_q[j+1].rr  <= ge ? rcvg_pkg::MOD_W'(t - {1'b0, rcvg_pkg::PI_Q16})
                            : t[rcvg_pkg::MOD_W-1:0];
        ix_q[j+1].low <= {cur.low[IdxW-2:0], 1'b0};
        ix_q[j+1].idx <= {cur.idx[IdxW-2:0], ge};
      end
    end
  end

  // Gain table, built from constants at elaboration and read through a register.
  logic [rcvg_pkg::GAIN_W-1:0] rom [GAIN_TABLE_DEPTH];

  for (genvar e = 0; e < GAIN_TABLE_DEPTH; e++) begin : g_rom
    assign rom[e] = cos4_entry(e);
  end

  logic                               g_v_q, p_v_q, o_v_q;
  logic [rcvg_pkg::LIGHT_W-1:0]       g_lin_q;
  logic [rcvg_pkg::GAIN_W-1:0]        gain_q, p_gain_q;
  logic [rcvg_pkg::LIGHT_W+rcvg_pkg::GAIN_W-1:0] prod_q;
  logic [rcvg_pkg::LIGHT_W-1:0]       q0;
  logic [rcvg_pkg::GAIN_W:0]          rsum;
  rcvg_pkg::item_out_t                res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
      p_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      g_v_q <= ix_q[IdxW].v;
      p_v_q <= g_v_q;
      o_v_q <= p_v_q;
    end
  end

  // Division by 65535: quotient from the top half, one correction step.
  assign q0   = prod_q[rcvg_pkg::LIGHT_W+rcvg_pkg::GAIN_W-1 -: rcvg_pkg::LIGHT_W];
  assign rsum = {1'b0, prod_q[rcvg_pkg::GAIN_W-1:0]} + (rcvg_pkg::GAIN_W+1)'(q0);

  always_ff @(posedge clk_i) begin
    gain_q   <= rom[ix_q[IdxW].idx];
    g_lin_q  <= ix_q[IdxW].lin;
    prod_q   <= g_lin_q * gain_q;
    p_gain_q <= gain_q;
    res_q.lightness_out <= q0 + rcvg_pkg::LIGHT_W'(rsum >= 17'd65535);
    res_q.radial_gain   <= p_gain_q;
  end

  assign strobe_o = o_v_q;
  assign result_o = res_q;

endmodule

[hdl/radial_cos4_vignette_gain.sv]
// Top level of the cos^4 radial vignette gain block.
//
//  Channel   Ports                                  Transfer
//  input     start, busy, item_i                    edge with start high, busy low
//  result    strobe_o, result_o                     edge ending the strobe cycle
//  config    cfg_we_i, cfg_idx_i, cfg_data_i        edge with cfg_we_i high
//
// One item per clock while busy is low; each result passes the radius square root, angle divider
// and index stages, the gain lookup and the scaling after its item is taken.
// Writing a size register raises busy while the corner distance square root iterates;
// a strength write raises it for one cycle.
// After reset the block accepts items at once. Results cannot be stalled.
`timescale 1ns / 1ps
module radial_cos4_vignette_gain #(
  parameter int unsigned MAX_DIM          = 4096,
  parameter int unsigned GAIN_TABLE_DEPTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  rcvg_pkg::item_in_t              item_i,
  output logic                            strobe_o,
  output rcvg_pkg::item_out_t             result_o,
  input  logic                            cfg_we_i,
  input  logic [rcvg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rcvg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  rcvg_pkg::cfg_view_t   view;
  rcvg_pkg::fifo_entry_t push_data, pop_data;
  logic cfg_busy, front_stall, take, push, full, empty;

  assign busy = cfg_busy || front_stall;
  assign take = start && !busy;

  rcvg_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .view_o     (view),
    .busy_o     (cfg_busy)
  );

  rcvg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .item_i  (item_i),
    .view_i  (view),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_data),
    .stall_o (front_stall)
  );

  rcvg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .pop_i   (!empty),
    .rdata_o (pop_data),
    .full_o  (full),
    .empty_o (empty)
  );

  rcvg_back #(.GAIN_TABLE_DEPTH(GAIN_TABLE_DEPTH)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (!empty),
    .entry_i  (pop_data),
    .view_i   (view),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

endmodule
